// File: design/rsg_pkg.sv
// Shared types and constants for the width reshard segment generator.
// Used by the front end, back end and top level; no dependencies of its own.
package rsg_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOCAL_WIDTH   = 3'd0,
    CFG_REMOTE_WIDTH  = 3'd1,
    CFG_ELEMENT_BYTES = 3'd2,
    CFG_LOCAL_COUNT   = 3'd3,
    CFG_REMOTE_COUNT  = 3'd4
  } cfg_addr_t;

  typedef struct packed {
    logic [15:0] local_width;
    logic [15:0] remote_width;
    logic [4:0]  element_bytes;
    logic [7:0]  local_count;
    logic [7:0]  remote_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    local_width:   16'd1,
    remote_width:  16'd1,
    element_bytes: 5'd2,
    local_count:   8'd1,
    remote_count:  8'd1
  };

  localparam logic [4:0] ELEM_BYTES_MAX = 5'd16;

  // What the back end has to do with one item.
  typedef enum logic [1:0] {
    CMD_RUN  = 2'd0,
    CMD_SKIP = 2'd1,
    CMD_PAST = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

endpackage

// File: design/rsg_front.sv
// Front end: accepts items, tracks the local shard position and classifies
// each item into a back-end command. Depends on rsg_pkg.
module rsg_front #(
  parameter int PW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_restart,
  input  logic [15:0]           local_width,
  input  logic [PW-1:0]         local_count,
  input  logic                  cmd_full,
  output logic                  cmd_push,
  output rsg_pkg::cmd_kind_t    cmd_kind,
  output logic                  cmd_restart,
  output logic                  cmd_last_local,
  output logic [PW-1:0]         cmd_index
);

  logic [PW-1:0] local_pos_r;
  logic [PW-1:0] local_pos_nxt;
  logic [PW-1:0] pos;
  logic [PW:0]   pos_inc;
  logic          past;

  assign in_stall = cmd_full;
  assign cmd_push = in_valid && !cmd_full;

  always_comb begin
    pos     = in_restart ? '0 : local_pos_r;
    pos_inc = {1'b0, pos} + {{PW{1'b0}}, 1'b1};
    past    = pos >= local_count;
    if (past) begin
      cmd_kind = rsg_pkg::CMD_PAST;
    end else if (local_width == 16'd0) begin
      cmd_kind = rsg_pkg::CMD_SKIP;
    end else begin
      cmd_kind = rsg_pkg::CMD_RUN;
    end
    cmd_restart    = in_restart;
    cmd_index      = pos;
    cmd_last_local = pos_inc >= {1'b0, local_count};
    // hold position on a shard past the end, advance otherwise
    local_pos_nxt  = past ? pos : pos_inc[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_pos_r <= '0;
    end else if (cmd_push) begin
      local_pos_r <= local_pos_nxt;
    end
  end

endmodule

// File: design/rsg_cmd_fifo.sv
// Two-entry command queue between front and back end.
// Generic payload width; no package dependencies.
module rsg_cmd_fifo #(
  parameter int W = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// File: design/rsg_back.sv
// Back end: takes commands from the queue, walks the remote shards one
// segment per cycle unless the output stalls, and drives the output register. Depends on rsg_pkg.
module rsg_back #(
  parameter int PW = 8,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        local_width,
  input  logic [15:0]        remote_width,
  input  logic [4:0]         elem_bytes,
  input  logic [PW-1:0]      remote_count,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  rsg_pkg::cmd_kind_t cmd_kind,
  input  logic               cmd_restart,
  input  logic               cmd_last_local,
  input  logic [PW-1:0]      cmd_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_local_index,
  output logic [19:0]        out_length_bytes,
  output logic [19:0]        out_local_offset_bytes,
  output logic [6:0]         out_remote_index,
  output logic [19:0]        out_remote_offset_bytes,
  output logic               out_last_of_shard,
  output logic               out_overrun
);

  localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [SW-1:0] SEG_LAST = SW'(MAX_SEGMENTS - 1);

  function automatic logic [19:0] to_bytes(input logic [4:0] eb, input logic [15:0] n);
    logic [20:0] p;
    p = 21'(eb) * 21'(n);
    return p[19:0];
  endfunction

  rsg_pkg::back_state_t state_r, state_nxt;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   fill_r, fill_nxt;
  logic [15:0]   loff_r, loff_nxt;
  logic [SW-1:0] seg_r, seg_nxt;
  logic [PW-1:0] idx_r;
  logic          last_local_r;

  logic          adv;
  logic          emit;
  logic          done;
  logic [6:0]    e_li;
  logic [19:0]   e_len;
  logic [19:0]   e_loff;
  logic [6:0]    e_ri;
  logic [19:0]   e_roff;
  logic          e_last;
  logic          e_ovr;

  logic [PW-1:0] pos_a;
  logic [PW:0]   pos_a_inc;
  logic [15:0]   fill_a;
  logic          over_remote;
  logic          final_seg;
  logic [15:0]   rem_in;
  logic [15:0]   rem_out;
  logic [15:0]   take;
  logic [16:0]   loff_sum;
  logic [15:0]   fill_sum;
  logic          shard_done;
  logic          seg_limit;

  logic          out_valid_r;
  logic [6:0]    li_r;
  logic [19:0]   len_r;
  logic [19:0]   loff_out_r;
  logic [6:0]    ri_r;
  logic [19:0]   roff_r;
  logic          last_r;
  logic          ovr_r;

  assign adv     = !out_valid_r || !out_stall;
  assign cmd_pop = (state_r == rsg_pkg::BK_IDLE) && cmd_valid && adv;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsg_pkg::BK_IDLE: begin
        if (cmd_pop && cmd_kind == rsg_pkg::CMD_RUN) begin
          state_nxt = rsg_pkg::BK_RUN;
        end
      end
      rsg_pkg::BK_RUN: begin
        if (adv && done) begin
          state_nxt = rsg_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rsg_pkg::BK_IDLE;
    endcase
  end

  // segment arithmetic for the current remote shard
  always_comb begin
    if (fill_r >= remote_width) begin
      fill_a = 16'd0;
      pos_a  = (pos_r < remote_count) ? PW'({1'b0, pos_r} + {{PW{1'b0}}, 1'b1}) : pos_r;
    end else begin
      fill_a = fill_r;
      pos_a  = pos_r;
    end
    pos_a_inc   = {1'b0, pos_a} + {{PW{1'b0}}, 1'b1};
    over_remote = pos_a >= remote_count;
    final_seg   = last_local_r && (pos_a_inc >= {1'b0, remote_count});
    rem_in      = local_width - loff_r;
    rem_out     = remote_width - fill_a;
    if (final_seg) begin
      take = rem_out;
    end else begin
      take = (rem_in < rem_out) ? rem_in : rem_out;
    end
    loff_sum   = {1'b0, loff_r} + {1'b0, take};
    fill_sum   = fill_a + take;
    shard_done = final_seg || (loff_sum >= {1'b0, local_width});
    seg_limit  = seg_r == SEG_LAST;
  end

  // outputs of each state
  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    loff_nxt = loff_r;
    seg_nxt  = seg_r;
    emit     = 1'b0;
    done     = 1'b0;
    e_li     = 7'(idx_r);
    e_len    = 20'd0;
    e_loff   = 20'd0;
    e_ri     = 7'd0;
    e_roff   = 20'd0;
    e_last   = 1'b0;
    e_ovr    = 1'b0;
    unique case (state_r)
      rsg_pkg::BK_IDLE: begin
        if (cmd_pop) begin
          if (cmd_restart) begin
            pos_nxt  = '0;
            fill_nxt = 16'd0;
          end
          loff_nxt = 16'd0;
          seg_nxt  = '0;
          if (cmd_kind == rsg_pkg::CMD_PAST) begin
            emit   = 1'b1;
            e_li   = 7'(cmd_index);
            e_last = 1'b1;
            e_ovr  = 1'b1;
          end
        end
      end
      rsg_pkg::BK_RUN: begin
        if (adv) begin
          emit   = 1'b1;
          e_loff = to_bytes(elem_bytes, loff_r);
          e_ri   = 7'(pos_a);
          if (over_remote) begin
            // out of remote shards: report where the local shard stopped
            pos_nxt  = pos_a;
            fill_nxt = fill_a;
            e_last   = 1'b1;
            e_ovr    = 1'b1;
            done     = 1'b1;
          end else begin
            e_len  = to_bytes(elem_bytes, take);
            e_roff = to_bytes(elem_bytes, fill_a);
            if (fill_sum == remote_width) begin
              pos_nxt  = pos_a_inc[PW-1:0];
              fill_nxt = 16'd0;
            end else begin
              pos_nxt  = pos_a;
              fill_nxt = fill_sum;
            end
            loff_nxt = loff_sum[15:0];
            seg_nxt  = seg_r + SW'(1);
            done     = shard_done || seg_limit;
            e_last   = done;
            e_ovr    = !shard_done && seg_limit;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsg_pkg::BK_IDLE;
      pos_r   <= '0;
      fill_r  <= 16'd0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    loff_r <= loff_nxt;
    seg_r  <= seg_nxt;
    if (cmd_pop) begin
      idx_r        <= cmd_index;
      last_local_r <= cmd_last_local;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      li_r       <= e_li;
      len_r      <= e_len;
      loff_out_r <= e_loff;
      ri_r       <= e_ri;
      roff_r     <= e_roff;
      last_r     <= e_last;
      ovr_r      <= e_ovr;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_local_index         = li_r;
  assign out_length_bytes        = len_r;
  assign out_local_offset_bytes  = loff_out_r;
  assign out_remote_index        = ri_r;
  assign out_remote_offset_bytes = roff_r;
  assign out_last_of_shard       = last_r;
  assign out_overrun             = ovr_r;

endmodule

// File: design/width_reshard_segment_generator.sv
// Top level of the width reshard segment generator: configuration registers,
// front end, command queue and back end. Depends on rsg_pkg and all rsg_ modules.
//
// Each item on the input channel (in_valid / in_stall, payload in_restart)
// stands for the next local shard of a pass; in_restart = 1 starts a new pass.
// The block answers with the copy segments of that shard on the output
// channel (out_valid / out_stall), the last one marked by out_last_of_shard.
// Configuration is written through cfg_we / cfg_addr / cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce; register indexes follow rsg_pkg::cfg_addr_t.
// On its way to the output an item passes the command queue, the back end's run
// state and the output register; the single result of a shard past the end is
// registered as its command is taken from the queue. The back end issues one
// segment per cycle while the receiver does not stall, and takes each command
// from the queue in its idle state before it walks the remote shards; a shard
// past the end or of zero width is handled in the idle state alone.
// The two-entry command queue lets the front end keep accepting items while
// the back end works. When the receiver stalls, the output register holds its
// segment and the back end waits; the queue fills and then in_stall rises.
// Reset clears positions, queue and output valid and loads the register
// defaults (widths 1, two bytes per element, counts 1).
module width_reshard_segment_generator #(
  parameter int MAX_SHARDS   = 128,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_local_index,
  output logic [19:0] out_length_bytes,
  output logic [19:0] out_local_offset_bytes,
  output logic [6:0]  out_remote_index,
  output logic [19:0] out_remote_offset_bytes,
  output logic        out_last_of_shard,
  output logic        out_overrun,
  input  logic        cfg_we,
  input  logic [rsg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rsg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PW = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS + 1) : 1;
  localparam int KW = $bits(rsg_pkg::cmd_kind_t);
  localparam int CMD_W = KW + 2 + PW;

  rsg_pkg::cfg_t cfg_r;
  logic [PW-1:0] lc_eff;
  logic [PW-1:0] rc_eff;
  logic [4:0]    eb_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= rsg_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rsg_pkg::CFG_LOCAL_WIDTH:   cfg_r.local_width   <= cfg_wdata;
        rsg_pkg::CFG_REMOTE_WIDTH:  cfg_r.remote_width  <= cfg_wdata;
        rsg_pkg::CFG_ELEMENT_BYTES: cfg_r.element_bytes <= cfg_wdata[4:0];
        rsg_pkg::CFG_LOCAL_COUNT:   cfg_r.local_count   <= cfg_wdata[7:0];
        rsg_pkg::CFG_REMOTE_COUNT:  cfg_r.remote_count  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // clamp counts to the shard limit and element size to sixteen bytes
  always_comb begin
    lc_eff = (32'(cfg_r.local_count) > MAX_SHARDS) ? PW'(MAX_SHARDS)
                                                   : PW'(cfg_r.local_count);
    rc_eff = (32'(cfg_r.remote_count) > MAX_SHARDS) ? PW'(MAX_SHARDS)
                                                    : PW'(cfg_r.remote_count);
    eb_eff = (cfg_r.element_bytes > rsg_pkg::ELEM_BYTES_MAX) ? rsg_pkg::ELEM_BYTES_MAX
                                                             : cfg_r.element_bytes;
  end

  logic               f_push;
  rsg_pkg::cmd_kind_t f_kind;
  logic               f_restart;
  logic               f_last_local;
  logic [PW-1:0]      f_index;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;
  logic [CMD_W-1:0]   q_push_data;
  logic [CMD_W-1:0]   q_pop_data;
  rsg_pkg::cmd_kind_t b_kind;

  rsg_front #(
    .PW(PW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .local_width    (cfg_r.local_width),
    .local_count    (lc_eff),
    .cmd_full       (q_full),
    .cmd_push       (f_push),
    .cmd_kind       (f_kind),
    .cmd_restart    (f_restart),
    .cmd_last_local (f_last_local),
    .cmd_index      (f_index)
  );

  assign q_push_data = {f_kind, f_restart, f_last_local, f_index};

  rsg_cmd_fifo #(
    .W(CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  assign b_kind = rsg_pkg::cmd_kind_t'(q_pop_data[CMD_W-1 -: KW]);

  rsg_back #(
    .PW           (PW),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .local_width             (cfg_r.local_width),
    .remote_width            (cfg_r.remote_width),
    .elem_bytes              (eb_eff),
    .remote_count            (rc_eff),
    .cmd_valid               (q_not_empty),
    .cmd_pop                 (q_pop),
    .cmd_kind                (b_kind),
    .cmd_restart             (q_pop_data[PW+1]),
    .cmd_last_local          (q_pop_data[PW]),
    .cmd_index               (q_pop_data[PW-1:0]),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_local_index         (out_local_index),
    .out_length_bytes        (out_length_bytes),
    .out_local_offset_bytes  (out_local_offset_bytes),
    .out_remote_index        (out_remote_index),
    .out_remote_offset_bytes (out_remote_offset_bytes),
    .out_last_of_shard       (out_last_of_shard),
    .out_overrun             (out_overrun)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for width_reshard_segment_generator: directed shard table,
// then random passes under several config and idling phases. Depends on rsg_pkg.
module tb_top;

  localparam int MAX_SHARDS   = 128;
  localparam int MAX_SEGMENTS = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 200;
  localparam int FIRST_UNMAPPED_REG = 5;
  localparam int LAST_REG_INDEX = (1 << rsg_pkg::CFG_ADDR_W) - 1;

  typedef struct packed {
    logic [6:0]  local_index;
    logic [19:0] length_bytes;
    logic [19:0] local_offset_bytes;
    logic [6:0]  remote_index;
    logic [19:0] remote_offset_bytes;
    logic        last_of_shard;
    logic        overrun;
  } shard_seg_t;

  typedef struct packed {
    rsg_pkg::cfg_t cfg;
    logic          restart;
    logic          typed;
    shard_seg_t    want;
  } plan_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0]  out_local_index;
  logic [19:0] out_length_bytes;
  logic [19:0] out_local_offset_bytes;
  logic [6:0]  out_remote_index;
  logic [19:0] out_remote_offset_bytes;
  logic out_last_of_shard;
  logic out_overrun;
  logic cfg_we = 1'b0;
  logic [rsg_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [rsg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Mirror of the block: written config and pass position.
  rsg_pkg::cfg_t cur_cfg = rsg_pkg::CFG_RESET;
  int unsigned next_local = 0;
  int unsigned cur_remote = 0;
  int unsigned remote_used = 0;

  shard_seg_t shard_segs[$];
  shard_seg_t segs_due[$];
  plan_row_t  plan[$];

  int unsigned err_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;

  width_reshard_segment_generator #(
    .MAX_SHARDS(MAX_SHARDS),
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_local_index(out_local_index),
    .out_length_bytes(out_length_bytes),
    .out_local_offset_bytes(out_local_offset_bytes),
    .out_remote_index(out_remote_index),
    .out_remote_offset_bytes(out_remote_offset_bytes),
    .out_last_of_shard(out_last_of_shard),
    .out_overrun(out_overrun),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic rsg_pkg::cfg_t mk_cfg(input int unsigned lw, input int unsigned rw,
                                           input int unsigned eb, input int unsigned lc,
                                           input int unsigned rc);
    rsg_pkg::cfg_t c;
    c.local_width   = 16'(lw);
    c.remote_width  = 16'(rw);
    c.element_bytes = 5'(eb);
    c.local_count   = 8'(lc);
    c.remote_count  = 8'(rc);
    return c;
  endfunction

  function automatic shard_seg_t mk_seg(input int unsigned li, input int unsigned len,
                                        input int unsigned loff, input int unsigned ri,
                                        input int unsigned roff, input bit last,
                                        input bit ovr);
    shard_seg_t s;
    s.local_index         = 7'(li);
    s.length_bytes        = 20'(len);
    s.local_offset_bytes  = 20'(loff);
    s.remote_index        = 7'(ri);
    s.remote_offset_bytes = 20'(roff);
    s.last_of_shard       = last;
    s.overrun             = ovr;
    return s;
  endfunction

  // Copy segments of the next local shard into shard_segs; advance the pass.
  function automatic void predict_shard(input logic restart);
    int unsigned lw, rw, lc, rc, eb, loff, rem_in, rem_out, span;
    int k;
    bit fin;
    shard_seg_t s;
    lw = cur_cfg.local_width;
    rw = cur_cfg.remote_width;
    lc = (cur_cfg.local_count > MAX_SHARDS) ? MAX_SHARDS : cur_cfg.local_count;
    rc = (cur_cfg.remote_count > MAX_SHARDS) ? MAX_SHARDS : cur_cfg.remote_count;
    eb = (cur_cfg.element_bytes > rsg_pkg::ELEM_BYTES_MAX) ? rsg_pkg::ELEM_BYTES_MAX
                                                          : cur_cfg.element_bytes;
    loff = 0;
    k = 0;
    shard_segs.delete();
    if (restart) begin
      next_local = 0;
      cur_remote = 0;
      remote_used = 0;
    end
    if (next_local >= lc) begin
      shard_segs.insert(shard_segs.size(), mk_seg(next_local, 0, 0, 0, 0, 1'b1, 1'b1));
      return;
    end
    while (loff < lw) begin
      // a full remote shard moves on before anything is copied
      if (remote_used >= rw) begin
        if (cur_remote < rc) cur_remote++;
        remote_used = 0;
      end
      if (cur_remote >= rc) begin
        shard_segs.insert(shard_segs.size(),
                          mk_seg(next_local, 0, eb * loff, cur_remote, 0, 1'b1, 1'b1));
        break;
      end
      fin = (next_local + 1 >= lc) && (cur_remote + 1 >= rc);
      rem_in = lw - loff;
      rem_out = rw - remote_used;
      span = fin ? rem_out : ((rem_in < rem_out) ? rem_in : rem_out);
      s = mk_seg(next_local, eb * span, eb * loff, cur_remote, eb * remote_used, 1'b0, 1'b0);
      k++;
      loff += span;
      remote_used += span;
      if (remote_used == rw) begin
        cur_remote++;
        remote_used = 0;
      end
      if (fin || loff >= lw) begin
        s.last_of_shard = 1'b1;
        shard_segs.insert(shard_segs.size(), s);
        break;
      end
      if (k >= MAX_SEGMENTS) begin
        // drop the rest of this shard
        s.last_of_shard = 1'b1;
        s.overrun = 1'b1;
        shard_segs.insert(shard_segs.size(), s);
        break;
      end
      shard_segs.insert(shard_segs.size(), s);
    end
    next_local++;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got_v,
                               input int unsigned want_v);
    err_count++;
    $display("t=%0t %s: got %0d, want %0d", $time, what, got_v, want_v);
  endtask

  task automatic check_segment();
    shard_seg_t got, want;
    got = mk_seg(out_local_index, out_length_bytes, out_local_offset_bytes,
                 out_remote_index, out_remote_offset_bytes, out_last_of_shard, out_overrun);
    if (segs_due.size() == 0) begin
      flag_mismatch("segment with none outstanding", got.length_bytes, 0);
      return;
    end
    want = segs_due.pop_front();
    if (got.local_index !== want.local_index)
      flag_mismatch("local_index", got.local_index, want.local_index);
    if (got.length_bytes !== want.length_bytes)
      flag_mismatch("length_bytes", got.length_bytes, want.length_bytes);
    if (got.local_offset_bytes !== want.local_offset_bytes)
      flag_mismatch("local_offset_bytes", got.local_offset_bytes, want.local_offset_bytes);
    if (got.remote_index !== want.remote_index)
      flag_mismatch("remote_index", got.remote_index, want.remote_index);
    if (got.remote_offset_bytes !== want.remote_offset_bytes)
      flag_mismatch("remote_offset_bytes", got.remote_offset_bytes, want.remote_offset_bytes);
    if (got.last_of_shard !== want.last_of_shard)
      flag_mismatch("last_of_shard", got.last_of_shard, want.last_of_shard);
    if (got.overrun !== want.overrun)
      flag_mismatch("overrun", got.overrun, want.overrun);
  endtask

  // Result side: check, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) check_segment();
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Offer one item; on acceptance queue what it should produce.
  task automatic push_item(input logic rb, input logic typed, input shard_seg_t want);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_restart <= rb;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_shard(rb);
    if (typed) segs_due.insert(segs_due.size(), want);
    else foreach (shard_segs[j]) segs_due.insert(segs_due.size(), shard_segs[j]);
  endtask

  // Drop valid and wait for every outstanding segment, plus a margin.
  task automatic settle(input int unsigned margin);
    in_valid <= 1'b0;
    do @(posedge clk); while (segs_due.size() != 0);
    repeat (margin) @(posedge clk);
  endtask

  task automatic set_config(input rsg_pkg::cfg_t c, input bit dirty);
    logic [15:0] junk;
    junk = dirty ? 16'($urandom) : 16'd0;
    cfg_we <= 1'b1;
    if (dirty) begin
      // unmapped index must be ignored
      cfg_addr <= rsg_pkg::CFG_ADDR_W'($urandom_range(FIRST_UNMAPPED_REG, LAST_REG_INDEX));
      cfg_wdata <= junk;
      @(posedge clk);
    end
    cfg_addr <= rsg_pkg::CFG_LOCAL_WIDTH;
    cfg_wdata <= c.local_width;
    @(posedge clk);
    cfg_addr <= rsg_pkg::CFG_REMOTE_WIDTH;
    cfg_wdata <= c.remote_width;
    @(posedge clk);
    cfg_addr <= rsg_pkg::CFG_ELEMENT_BYTES;
    cfg_wdata <= {junk[15:5], c.element_bytes};
    @(posedge clk);
    cfg_addr <= rsg_pkg::CFG_LOCAL_COUNT;
    cfg_wdata <= {junk[15:8], c.local_count};
    @(posedge clk);
    cfg_addr <= rsg_pkg::CFG_REMOTE_COUNT;
    cfg_wdata <= {junk[15:8], c.remote_count};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic add_row(input rsg_pkg::cfg_t c, input logic rb, input logic typed,
                         input shard_seg_t want);
    plan_row_t r;
    r.cfg = c;
    r.restart = rb;
    r.typed = typed;
    r.want = want;
    plan.insert(plan.size(), r);
  endtask

  function automatic rsg_pkg::cfg_t pick_cfg();
    rsg_pkg::cfg_t c;
    int unsigned kind;
    kind = $urandom_range(0, 19);
    c = mk_cfg($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 16),
               $urandom_range(1, 8), $urandom_range(1, 12));
    case (kind)
      0: begin
        c.local_width = 16'($urandom_range(0, 65535));
        c.remote_width = 16'($urandom_range(0, 65535));
      end
      1: c.element_bytes = 5'($urandom_range(0, 31));
      2: begin
        c.local_count = 8'($urandom_range(0, 255));
        c.remote_count = 8'($urandom_range(0, 255));
      end
      3: begin
        if ($urandom_range(0, 1)) c.remote_width = '0;
        else c.local_width = '0;
      end
      4: begin
        c.local_width = 16'($urandom_range(1000, 65535));
        c.remote_width = 16'($urandom_range(c.local_width / 4 + 1, 65535));
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin : stimulus
    rsg_pkg::cfg_t c;
    logic rb;
    int unsigned sent, phase, n, lc_eff, pass_len, span;
    sent = 0;
    phase = 0;
    pass_len = 0;
    span = 0;

    // Defaults after reset
    add_row(rsg_pkg::CFG_RESET, 1'b0, 1'b1, mk_seg(0, 2, 0, 0, 0, 1'b1, 1'b0));
    add_row(rsg_pkg::CFG_RESET, 1'b0, 1'b1, mk_seg(1, 0, 0, 0, 0, 1'b1, 1'b1));
    add_row(rsg_pkg::CFG_RESET, 1'b1, 1'b1, mk_seg(0, 2, 0, 0, 0, 1'b1, 1'b0));
    // A shard over a few remote shards, then past the last local shard
    c = mk_cfg(10, 4, 3, 3, 8);
    add_row(c, 1'b1, 1'b0, '0);
    add_row(c, 1'b0, 1'b0, '0);
    add_row(c, 1'b0, 1'b0, '0);
    add_row(c, 1'b0, 1'b1, mk_seg(3, 0, 0, 0, 0, 1'b1, 1'b1));
    // Widest fields
    c = mk_cfg(65535, 65535, 16, 128, 128);
    add_row(c, 1'b1, 1'b1, mk_seg(0, 1048560, 0, 0, 0, 1'b1, 1'b0));
    add_row(c, 1'b0, 1'b0, '0);
    // Oversized element size and counts clamp
    add_row(mk_cfg(1, 1, 31, 255, 200), 1'b1, 1'b1, mk_seg(0, 16, 0, 0, 0, 1'b1, 1'b0));
    // Zero element size
    add_row(mk_cfg(5, 2, 0, 2, 4), 1'b1, 1'b0, '0);
    // Zero local count
    add_row(mk_cfg(4, 4, 2, 0, 4), 1'b1, 1'b1, mk_seg(0, 0, 0, 0, 0, 1'b1, 1'b1));
    // Zero local width: no segments, position still moves
    c = mk_cfg(0, 4, 2, 2, 4);
    add_row(c, 1'b1, 1'b0, '0);
    add_row(c, 1'b0, 1'b0, '0);
    add_row(c, 1'b0, 1'b1, mk_seg(2, 0, 0, 0, 0, 1'b1, 1'b1));
    // Zero remote width
    add_row(mk_cfg(3, 0, 1, 2, 4), 1'b1, 1'b0, '0);
    // Segment limit
    c = mk_cfg(200, 3, 1, 2, 128);
    add_row(c, 1'b1, 1'b0, '0);
    add_row(c, 1'b0, 1'b0, '0);
    // Running past the last remote shard
    add_row(mk_cfg(10, 4, 2, 4, 2), 1'b1, 1'b0, '0);
    // Remote width shrinks mid pass
    add_row(mk_cfg(3, 5, 1, 4, 8), 1'b1, 1'b0, '0);
    add_row(mk_cfg(3, 2, 1, 4, 8), 1'b0, 1'b0, '0);
    // Last local on last remote takes the remote remainder
    c = mk_cfg(3, 10, 2, 2, 1);
    add_row(c, 1'b1, 1'b0, '0);
    add_row(c, 1'b0, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].cfg != cur_cfg) begin
        settle(8);
        set_config(plan[i].cfg, 1'b0);
      end
      push_item(plan[i].restart, plan[i].typed, plan[i].want);
    end

    while (sent < RANDOM_ITEMS) begin
      c = pick_cfg();
      settle(8);
      set_config(c, 1'b1);
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
        default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
      endcase
      // Long receiver hold while items keep coming: queue fills, input stalls
      if (phase == 2) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req = 1'b1;
      end
      lc_eff = (c.local_count > MAX_SHARDS) ? MAX_SHARDS : c.local_count;
      n = $urandom_range(8, 30);
      // Most phases start a fresh pass; some carry the old pass over
      if ($urandom_range(0, 3) != 0) span = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (phase == 5 && i == n / 2) settle(0);
        rb = (span == 0) || ($urandom_range(0, 15) == 0);
        if (rb) begin
          span = 0;
          pass_len = lc_eff + (($urandom_range(0, 3) == 0) ? 1 : 0);
        end
        push_item(rb, 1'b0, '0);
        span++;
        if (span >= pass_len) span = 0;
        sent++;
      end
      phase++;
    end

    rx_stall_pct = 0;
    settle(16);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
